@@ rtl/lmsanf_pkg.sv @@
package lmsanf_pkg;

    localparam int TAPS_DEF  = 32;
    localparam int SAMPLE_W  = 16;
    localparam int OUT_W     = 32;
    localparam int DIV_W     = 15;
    localparam int QBITS     = 11;
    localparam int QHALF     = 1 << (QBITS - 1);
    localparam int ERR_W     = 33;
    localparam int STEP_W    = ERR_W + 2;
    localparam int PROD_W    = STEP_W + SAMPLE_W;
    localparam int HIST_W    = 2 * SAMPLE_W;
    localparam int DIV_STEPS = ERR_W;

    localparam logic [DIV_W-1:0] DIV_RESET = 15'd16;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DOT  = 5'b00010,
        ST_EMIT = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_UPD  = 5'b10000
    } state_t;

    typedef struct packed {
        logic                    start;
        logic signed [ERR_W-1:0] dividend;
        logic [DIV_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ERR_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/lmsanf_ram.sv @@
module lmsanf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/lmsanf_div.sv @@
module lmsanf_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lmsanf_pkg::div_req_t req,
    output lmsanf_pkg::div_rsp_t rsp
);

    import lmsanf_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic                    busy_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    neg_reg;
    logic [ERR_W-1:0]        quo_reg;
    logic [DIV_W-1:0]        rem_reg;
    logic [DIV_W-1:0]        dsr_reg;
    logic                    done_reg;
    logic signed [ERR_W-1:0] q_out_reg;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_sub;
    logic             ge;
    logic [DIV_W-1:0] rem_next;
    logic [ERR_W-1:0] quo_next;
    logic [ERR_W-1:0] mag_in;

    assign rem_sh   = {rem_reg, quo_reg[ERR_W-1]};
    assign ge       = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub  = rem_sh - {1'b0, dsr_reg};
    assign rem_next = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    assign quo_next = {quo_reg[ERR_W-2:0], ge};
    assign mag_in   = req.dividend[ERR_W-1] ? ERR_W'(-req.dividend) : ERR_W'(req.dividend);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_STEPS);
                neg_reg  <= req.dividend[ERR_W-1];
                quo_reg  <= mag_in;
                rem_reg  <= '0;
                dsr_reg  <= (req.divisor == '0) ? DIV_W'(1) : req.divisor;
            end else if (busy_reg) begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    q_out_reg <= neg_reg ? -$signed(quo_next) : $signed(quo_next);
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_out_reg;

endmodule

@@ rtl/lmsanf_mac.sv @@
module lmsanf_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    input  logic signed [lmsanf_pkg::STEP_W-1:0]   mul_a,
    input  logic signed [lmsanf_pkg::SAMPLE_W-1:0] mul_b,
    output logic                                  out_valid,
    output logic [lmsanf_pkg::OUT_W-1:0]          term
);

    import lmsanf_pkg::*;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rnd;
    logic                     valid_reg;

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
        prod_reg <= prod_next;
    end

    // Q11: round half up, arithmetic shift, keep 32 bits
    assign rnd       = prod_reg + PROD_W'(QHALF);
    assign term      = rnd[QBITS+OUT_W-1:QBITS];
    assign out_valid = valid_reg;

endmodule

@@ rtl/lms_adaptive_noise_filter_core.sv @@
// A result is offered once the dot product over all taps is done and the output register is free.
// A new input is taken only once the last is through: the shared multiplier walks the taps
// once for the dot product and once for the weight update, with a 33-step divider between.
// The input may be taken while a result still waits on the output register.
// Reset (aresetn low, synchronous): histories and weights read as zero, divisor is 16.
module lms_adaptive_noise_filter_core #(
    parameter int TAPS = lmsanf_pkg::TAPS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lmsanf_pkg::DIV_W-1:0]     cfg_wr_data,   // step_divisor
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lmsanf_pkg::HIST_W-1:0]    s_axis_tdata,  // reference_sample (high half), primary_sample (low half)
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lmsanf_pkg::OUT_W-1:0]     m_axis_tdata   // filter_output
);

    import lmsanf_pkg::*;

    localparam int IW = $clog2(TAPS);
    localparam int CW = $clog2(TAPS + 1);

    function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
        return (p == IW'(TAPS - 1)) ? '0 : p + 1'b1;
    endfunction

    state_t state_reg, state_next;

    logic [DIV_W-1:0] div_reg;
    logic [IW-1:0]    wp_reg;
    logic [CW-1:0]    fill_reg;
    logic             wvalid_reg;
    logic [IW-1:0]    rp_reg;
    logic [IW-1:0]    idx_reg;
    logic             issue_reg;

    logic             rd_vld_reg;
    logic             rd_last_reg;
    logic             rd_first_reg;
    logic             rd_hv_reg;
    logic [IW-1:0]    rd_idx_reg;
    logic             mx_last_reg;
    logic [IW-1:0]    mx_idx_reg;
    logic [OUT_W-1:0] w_dly_reg;

    logic [OUT_W-1:0]           acc_reg;
    logic signed [SAMPLE_W-1:0] prim_old_reg;
    logic signed [STEP_W-1:0]   step_reg;
    logic [OUT_W-1:0]           m_tdata_reg;
    logic                       m_tvalid_reg;

    logic                       s_accept;
    logic                       slot_valid;
    logic                       out_free;
    logic [HIST_W-1:0]          hist_rdata;
    logic [OUT_W-1:0]           w_rdata;
    logic signed [SAMPLE_W-1:0] hist_ref;
    logic signed [SAMPLE_W-1:0] hist_prim;
    logic [OUT_W-1:0]           w_rd;
    logic signed [STEP_W-1:0]   mul_a;
    logic                       mac_valid;
    logic [OUT_W-1:0]           term;
    logic                       w_we;
    logic [OUT_W-1:0]           w_wdata;
    logic signed [ERR_W-1:0]    err;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;
    assign slot_valid    = (fill_reg == CW'(TAPS)) || (CW'(rp_reg) < fill_reg);

    lmsanf_ram #(.WIDTH(HIST_W), .DEPTH(TAPS)) u_hist_ram (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (wp_reg),
        .wdata (s_axis_tdata),
        .raddr (rp_reg),
        .rdata (hist_rdata)
    );

    lmsanf_ram #(.WIDTH(OUT_W), .DEPTH(TAPS)) u_weight_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (mx_idx_reg),
        .wdata (w_wdata),
        .raddr (idx_reg),
        .rdata (w_rdata)
    );

    assign hist_prim = rd_hv_reg ? $signed(hist_rdata[SAMPLE_W-1:0]) : '0;
    assign hist_ref  = rd_hv_reg ? $signed(hist_rdata[HIST_W-1:SAMPLE_W]) : '0;
    assign w_rd      = wvalid_reg ? w_rdata : '0;
    assign mul_a     = (state_reg == ST_UPD) ? step_reg : STEP_W'($signed(w_rd));

    lmsanf_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_vld_reg),
        .mul_a     (mul_a),
        .mul_b     (hist_ref),
        .out_valid (mac_valid),
        .term      (term)
    );

    assign w_we    = mac_valid && (state_reg == ST_UPD);
    assign w_wdata = w_dly_reg + term;

    assign err              = ERR_W'(prim_old_reg) - ERR_W'($signed(acc_reg));
    assign div_req.start    = (state_reg == ST_EMIT) && out_free;
    assign div_req.dividend = err;
    assign div_req.divisor  = div_reg;

    lmsanf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                if (mac_valid && mx_last_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                if (mac_valid && mx_last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            div_reg      <= DIV_RESET;
            wp_reg       <= '0;
            fill_reg     <= '0;
            wvalid_reg   <= 1'b0;
            issue_reg    <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= issue_reg;
            if (cfg_wr_en) begin
                div_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                wp_reg    <= ptr_inc(wp_reg);
                rp_reg    <= ptr_inc(wp_reg);
                idx_reg   <= '0;
                issue_reg <= 1'b1;
                acc_reg   <= '0;
                if (fill_reg != CW'(TAPS)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (issue_reg) begin
                rp_reg  <= ptr_inc(rp_reg);
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == IW'(TAPS - 1)) begin
                    issue_reg <= 1'b0;
                end
            end
            if (state_reg == ST_DOT && mac_valid) begin
                acc_reg <= acc_reg + term;
            end
            if (state_reg == ST_DOT && rd_vld_reg && rd_first_reg) begin
                prim_old_reg <= hist_prim;
            end
            if (m_tvalid_reg && m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (div_req.start) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= acc_reg;
            end
            if (state_reg == ST_DIV && div_rsp.done) begin
                step_reg  <= {div_rsp.quotient, 2'b00};
                rp_reg    <= wp_reg;
                idx_reg   <= '0;
                issue_reg <= 1'b1;
            end
            if (state_reg == ST_UPD && mac_valid && mx_last_reg) begin
                wvalid_reg <= 1'b1;
            end
        end
        rd_last_reg  <= (idx_reg == IW'(TAPS - 1));
        rd_first_reg <= (idx_reg == '0);
        rd_hv_reg    <= slot_valid;
        rd_idx_reg   <= idx_reg;
        mx_last_reg  <= rd_last_reg;
        mx_idx_reg   <= rd_idx_reg;
        w_dly_reg    <= w_rd;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule
